/* hdl/cdps_pkg.sv */
// ----------------------------------------------------------------------------
// cdps_pkg: shared definitions for the clock divider pair search
// Field widths, search limits, the controller-to-datapath command and
// status bundles, and the operand select of the shared divider.
// ----------------------------------------------------------------------------
package cdps_pkg;

    localparam int RATE_W = 27;
    localparam int BCK_W  = 6;
    localparam int MCK_W  = 8;
    localparam int MISS_W = 15;
    localparam int SEARCH_W = 14;
    localparam int PROD_W = 14;

    localparam int BASE_CLOCK_HZ_DEF = 80000000;
    localparam int MAX_BCK_DIV = 63;
    localparam int MAX_MCK_DIV = 255;
    localparam int MAX_RATIO   = MAX_MCK_DIV * MAX_BCK_DIV;
    localparam int START_MISS  = 32767;
    localparam int FIRST_BCK   = 2;

    // Operand set for the shared serial divider.
    typedef enum logic [1:0] {
        DIV_RATIO,
        DIV_TRIAL,
        DIV_ACH
    } div_sel_t;

    typedef struct packed {
        logic     load_rate;
        logic     set_zero;
        logic     div_start;
        div_sel_t div_sel;
        logic     latch_ratio;
        logic     set_low;
        logic     set_high;
        logic     init_search;
        logic     eval_trial;
        logic     next_d;
        logic     take_best;
        logic     make_prod;
        logic     set_err;
        logic     latch_ach;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic rate_zero;
        logic ratio_low;
        logic ratio_high;
        logic div_done;
        logic trial_exact;
        logic last_d;
        logic prod_zero;
        logic out_free;
    } status_t;

endpackage

/* hdl/cdps_div.sv */
// ----------------------------------------------------------------------------
// cdps_div: restoring serial divider
// One quotient bit per cycle, MSB first. The number of steps is given at
// start, so a dividend that is left-aligned needs only as many steps as it
// has significant bits. done pulses for one cycle with the results valid.
// ----------------------------------------------------------------------------
module cdps_div #(
    parameter int DIV_W = 28,
    parameter int CNT_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    input  logic [CNT_W-1:0] steps,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/cdps_dp.sv */
// ----------------------------------------------------------------------------
// cdps_dp: datapath of the clock divider pair search
// Holds the rate, ratio, search state, chosen pair and the result register,
// and shares one serial divider among the ratio, the trials and the
// achieved rate.
// ----------------------------------------------------------------------------
module cdps_dp #(
    parameter int BASE_CLOCK_HZ = cdps_pkg::BASE_CLOCK_HZ_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cdps_pkg::RATE_W-1:0]   requested_rate,
    input  cdps_pkg::cmd_t                cmd,
    output cdps_pkg::status_t             status,
    input  logic                          res_ready,
    output logic                          res_valid,
    output logic [cdps_pkg::BCK_W-1:0]    bit_clock_divider,
    output logic [cdps_pkg::MCK_W-1:0]    master_clock_divider,
    output logic [cdps_pkg::RATE_W-1:0]   achieved_rate,
    output logic                          error_flag
);

    localparam int BASE_W = $clog2(BASE_CLOCK_HZ + 1);
    localparam int DIV_W  = (BASE_W > cdps_pkg::RATE_W) ? BASE_W : cdps_pkg::RATE_W;
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam int PAD_W  = DIV_W - cdps_pkg::SEARCH_W;
    localparam logic [DIV_W-1:0] BASE_VAL = DIV_W'(BASE_CLOCK_HZ);

    localparam int BCK_W  = cdps_pkg::BCK_W;
    localparam int MCK_W  = cdps_pkg::MCK_W;
    localparam int RATE_W = cdps_pkg::RATE_W;
    localparam int MISS_W = cdps_pkg::MISS_W;
    localparam int PROD_W = cdps_pkg::PROD_W;

    logic [RATE_W-1:0] rate_reg;
    logic [DIV_W-1:0]  ratio_reg;
    logic [BCK_W-1:0]  d_reg;
    logic [MISS_W-1:0] best_miss_reg;
    logic [BCK_W-1:0]  best_d_reg;
    logic [MCK_W-1:0]  best_q_reg;
    logic [BCK_W-1:0]  bck_reg;
    logic [MCK_W-1:0]  mck_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [RATE_W-1:0] ach_reg;
    logic              err_reg;

    logic [BCK_W-1:0]  res_bck_reg;
    logic [MCK_W-1:0]  res_mck_reg;
    logic [RATE_W-1:0] res_ach_reg;
    logic              res_err_reg;
    logic              res_valid_reg, res_valid_next;

    logic [DIV_W-1:0]  div_dividend;
    logic [DIV_W-1:0]  div_divisor;
    logic [CNT_W-1:0]  div_steps;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic [DIV_W-1:0]  div_rem;

    logic              q_ok;
    logic              trial_exact;
    logic              trial_better;

    always_comb
    begin
        case (cmd.div_sel)
            cdps_pkg::DIV_RATIO:
            begin
                div_dividend = BASE_VAL;
                div_divisor  = DIV_W'(rate_reg);
                div_steps    = CNT_W'(DIV_W);
            end
            cdps_pkg::DIV_TRIAL:
            begin
                // Ratio is below 2^SEARCH_W here, so left-align it and
                // run only SEARCH_W steps.
                div_dividend = {ratio_reg[cdps_pkg::SEARCH_W-1:0], {PAD_W{1'b0}}};
                div_divisor  = DIV_W'(d_reg);
                div_steps    = CNT_W'(cdps_pkg::SEARCH_W);
            end
            cdps_pkg::DIV_ACH:
            begin
                div_dividend = BASE_VAL;
                div_divisor  = DIV_W'(prod_reg);
                div_steps    = CNT_W'(DIV_W);
            end
            default:
            begin
                div_dividend = BASE_VAL;
                div_divisor  = DIV_W'(rate_reg);
                div_steps    = CNT_W'(DIV_W);
            end
        endcase
    end

    cdps_div #(
        .DIV_W (DIV_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // A quotient of one or above the master divider limit is skipped.
    assign q_ok = (div_quo <= DIV_W'(cdps_pkg::MAX_MCK_DIV)) && (div_quo != DIV_W'(1));
    assign trial_exact  = q_ok && (div_rem == '0);
    assign trial_better = q_ok && (div_rem < DIV_W'(best_miss_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load_rate)
        begin
            rate_reg <= requested_rate;
        end
        if (cmd.latch_ratio)
        begin
            ratio_reg <= div_quo;
        end
        if (cmd.init_search)
        begin
            d_reg         <= BCK_W'(cdps_pkg::FIRST_BCK);
            best_miss_reg <= MISS_W'(cdps_pkg::START_MISS);
            best_d_reg    <= '0;
            best_q_reg    <= '0;
        end
        else if (cmd.eval_trial)
        begin
            if (trial_exact)
            begin
                bck_reg <= d_reg;
                mck_reg <= div_quo[MCK_W-1:0];
            end
            else if (trial_better)
            begin
                best_miss_reg <= div_rem[MISS_W-1:0];
                best_d_reg    <= d_reg;
                best_q_reg    <= div_quo[MCK_W-1:0];
            end
        end
        if (cmd.next_d)
        begin
            d_reg <= d_reg + BCK_W'(1);
        end
        if (cmd.set_low)
        begin
            bck_reg <= BCK_W'(1);
            mck_reg <= MCK_W'(2);
        end
        if (cmd.set_high)
        begin
            bck_reg <= BCK_W'(cdps_pkg::MAX_BCK_DIV);
            mck_reg <= MCK_W'(cdps_pkg::MAX_MCK_DIV);
        end
        if (cmd.take_best)
        begin
            bck_reg <= best_d_reg;
            mck_reg <= best_q_reg;
        end
        if (cmd.set_zero)
        begin
            bck_reg <= '0;
            mck_reg <= '0;
            ach_reg <= '0;
            err_reg <= 1'b1;
        end
        if (cmd.make_prod)
        begin
            prod_reg <= PROD_W'(bck_reg) * PROD_W'(mck_reg);
        end
        if (cmd.set_err)
        begin
            ach_reg <= '0;
            err_reg <= 1'b1;
        end
        if (cmd.latch_ach)
        begin
            ach_reg <= div_quo[RATE_W-1:0];
            err_reg <= 1'b0;
        end
        if (cmd.load_out)
        begin
            res_bck_reg <= bck_reg;
            res_mck_reg <= mck_reg;
            res_ach_reg <= ach_reg;
            res_err_reg <= err_reg;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.load_out)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    assign status.rate_zero   = (rate_reg == '0);
    assign status.ratio_low   = (ratio_reg <= DIV_W'(2));
    assign status.ratio_high  = (ratio_reg > DIV_W'(cdps_pkg::MAX_RATIO));
    assign status.div_done    = div_done;
    assign status.trial_exact = trial_exact;
    assign status.last_d      = (d_reg == BCK_W'(cdps_pkg::MAX_BCK_DIV));
    assign status.prod_zero   = (prod_reg == '0);
    assign status.out_free    = !res_valid_reg || res_ready;

    assign res_valid            = res_valid_reg;
    assign bit_clock_divider    = res_bck_reg;
    assign master_clock_divider = res_mck_reg;
    assign achieved_rate        = res_ach_reg;
    assign error_flag           = res_err_reg;

endmodule

/* hdl/cdps_ctrl.sv */
// ----------------------------------------------------------------------------
// cdps_ctrl: sequencer of the clock divider pair search
// Steps one request through the ratio division, the divider trials, the
// product and the achieved-rate division, and hands the result over.
// ----------------------------------------------------------------------------
module cdps_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  cdps_pkg::status_t status,
    output cdps_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RATIO_WAIT,
        S_CLASSIFY,
        S_TRIAL,
        S_TRIAL_WAIT,
        S_TAKE_BEST,
        S_PROD,
        S_PROD_CHECK,
        S_ACH_WAIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_sel = cdps_pkg::DIV_RATIO;
        req_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_rate = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.rate_zero)
                begin
                    cmd.set_zero = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = cdps_pkg::DIV_RATIO;
                    state_next    = S_RATIO_WAIT;
                end
            end
            S_RATIO_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.latch_ratio = 1'b1;
                    state_next      = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                if (status.ratio_low)
                begin
                    cmd.set_low = 1'b1;
                    state_next  = S_PROD;
                end
                else if (status.ratio_high)
                begin
                    cmd.set_high = 1'b1;
                    state_next   = S_PROD;
                end
                else
                begin
                    cmd.init_search = 1'b1;
                    state_next      = S_TRIAL;
                end
            end
            S_TRIAL:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = cdps_pkg::DIV_TRIAL;
                state_next    = S_TRIAL_WAIT;
            end
            S_TRIAL_WAIT:
            begin
                cmd.div_sel = cdps_pkg::DIV_TRIAL;
                if (status.div_done)
                begin
                    cmd.eval_trial = 1'b1;
                    if (status.trial_exact)
                    begin
                        state_next = S_PROD;
                    end
                    else if (status.last_d)
                    begin
                        state_next = S_TAKE_BEST;
                    end
                    else
                    begin
                        cmd.next_d = 1'b1;
                        state_next = S_TRIAL;
                    end
                end
            end
            S_TAKE_BEST:
            begin
                cmd.take_best = 1'b1;
                state_next    = S_PROD;
            end
            S_PROD:
            begin
                cmd.make_prod = 1'b1;
                state_next    = S_PROD_CHECK;
            end
            S_PROD_CHECK:
            begin
                if (status.prod_zero)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = cdps_pkg::DIV_ACH;
                    state_next    = S_ACH_WAIT;
                end
            end
            S_ACH_WAIT:
            begin
                cmd.div_sel = cdps_pkg::DIV_ACH;
                if (status.div_done)
                begin
                    cmd.latch_ach = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/clock_divider_pair_search.sv */
// ----------------------------------------------------------------------------
// clock_divider_pair_search: sample-clock divider pair search
// Turns a requested sample rate into a bit-clock divider and a master-clock
// divider whose product best matches base clock / rate, and reports the
// rate that the chosen pair achieves.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake             | Beat contents
//   ---------+-----------------------+------------------------------------------
//   request  | req_valid / req_ready | requested_rate
//   result   | res_valid / res_ready | bit_clock_divider, master_clock_divider,
//            |                       | achieved_rate, error_flag
//
// One request is worked on at a time. A zero rate gives the quickest beat, and
// a beat takes longest when all 62 trial divisors are tried. The time is set
// by a single shared restoring divider that retires one quotient bit per
// cycle: two full divisions of DIV_W steps (DIV_W is the larger of 27 and
// the width of BASE_CLOCK_HZ) and up to 62 trial divisions of 14 steps.
// Reset clears the sequencer and the result valid flag; no clearing pass is
// needed. A finished result sits in an output register, so a new request
// beat is taken while the previous result beat still waits for res_ready;
// the sequencer only stalls at the end of a request if that register is
// still full.
//
module clock_divider_pair_search #(
    parameter int BASE_CLOCK_HZ = cdps_pkg::BASE_CLOCK_HZ_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [cdps_pkg::RATE_W-1:0]   requested_rate,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [cdps_pkg::BCK_W-1:0]    bit_clock_divider,
    output logic [cdps_pkg::MCK_W-1:0]    master_clock_divider,
    output logic [cdps_pkg::RATE_W-1:0]   achieved_rate,
    output logic                          error_flag
);

    // Commands from the sequencer and status back from the datapath are
    // the only connections between the two halves.
    cdps_pkg::cmd_t    cmd;
    cdps_pkg::status_t status;

    // The sequencer walks the special cases first: a zero rate ends at once
    // with the error flag, a ratio of at most two or above the divider limit
    // picks a fixed pair, and everything else runs the trial search.
    cdps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath keeps the first exact fit, or else the divider with the
    // smallest remainder (the earliest one on ties). A zero master divider,
    // which only arises for a ratio of three, raises the error flag.
    cdps_dp #(
        .BASE_CLOCK_HZ (BASE_CLOCK_HZ)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .requested_rate       (requested_rate),
        .cmd                  (cmd),
        .status               (status),
        .res_ready            (res_ready),
        .res_valid            (res_valid),
        .bit_clock_divider    (bit_clock_divider),
        .master_clock_divider (master_clock_divider),
        .achieved_rate        (achieved_rate),
        .error_flag           (error_flag)
    );

endmodule

/* bench/tb_clock_divider_pair_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_divider_pair_search: self-checking bench for the divider pair search
// Sends requested sample rates through the request channel and compares every
// result beat with its expected divider pair, achieved rate and error flag,
// from a corner-table row or a behavioral prediction. A short table of corner
// rates comes first, then random rates weighted toward the trial-divisor search,
// with random idle cycles on both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_clock_divider_pair_search;

    localparam int RATE_W = cdps_pkg::RATE_W;
    localparam int BCK_W  = cdps_pkg::BCK_W;
    localparam int MCK_W  = cdps_pkg::MCK_W;

    // Base clock of the instance; the design default is used.
    localparam int unsigned BASE_HZ = 80000000;

    // Search limits of the divider pair.
    localparam int unsigned LOWEST_TRIAL = 2;
    localparam int unsigned TOP_BCK      = 63;
    localparam int unsigned TOP_MCK      = 255;
    localparam int unsigned TOP_RATIO    = TOP_BCK * TOP_MCK;
    localparam int unsigned NO_MISS_YET  = 32767;

    // Run shape.
    localparam int RANDOM_ITEMS     = 535;
    localparam int NO_GAP_FIRST     = 150;
    localparam int NO_GAP_LAST      = 210;
    localparam int PRESSURE_AT      = 320;
    localparam int PRESSURE_CYCLES  = 4000;
    localparam int DRAIN_CYCLES     = 1200;
    localparam int unsigned LIMIT_NS = 25000000;

    // One result beat, field by field.
    typedef struct packed {
        logic [BCK_W-1:0]  bit_clock_divider;
        logic [MCK_W-1:0]  master_clock_divider;
        logic [RATE_W-1:0] achieved_rate;
        logic              error_flag;
    } divider_pair_t;

    // One row of the corner table. When typed is set the expected beat is
    // taken from the row itself; otherwise the predictor supplies it.
    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic              typed;
        divider_pair_t     want;
    } rate_row_t;

    localparam divider_pair_t NO_PAIR = '0;

    localparam rate_row_t CORNER_ROWS [18] = '{
        // Zero rate: all fields cleared, error raised.
        '{27'd0,         1'b1, '{6'd0,  8'd0,   27'd0,        1'b1}},
        // Lowest nonzero rate: ratio far above the search range.
        '{27'd1,         1'b1, '{6'd63, 8'd255, 27'd4979,     1'b0}},
        // Largest encodable rate, above the base clock: ratio of zero.
        '{27'd134217727, 1'b1, '{6'd1,  8'd2,   27'd40000000, 1'b0}},
        // Rate equal to the base clock: ratio of one.
        '{27'd80000000,  1'b1, '{6'd1,  8'd2,   27'd40000000, 1'b0}},
        // Ratio of exactly two.
        '{27'd40000000,  1'b1, '{6'd1,  8'd2,   27'd40000000, 1'b0}},
        // Lowest rate that still gives a ratio of two.
        '{27'd26666667,  1'b0, NO_PAIR},
        // Ratio of three at both ends of its band: zero master divider.
        '{27'd26666666,  1'b1, '{6'd4,  8'd0,   27'd0,        1'b1}},
        '{27'd20000001,  1'b1, '{6'd4,  8'd0,   27'd0,        1'b1}},
        // Ratio of four: exact fit at the first trial divisor.
        '{27'd20000000,  1'b1, '{6'd2,  8'd2,   27'd20000000, 1'b0}},
        // Ratio of five: no exact fit, first candidate kept.
        '{27'd16000000,  1'b0, NO_PAIR},
        // Ratio of six and of two times the largest master divider.
        '{27'd13333333,  1'b1, '{6'd2,  8'd3,   27'd13333333, 1'b0}},
        '{27'd156862,    1'b1, '{6'd2,  8'd255, 27'd156862,   1'b0}},
        // Prime ratio above the master limit: best remainder wins.
        '{27'd157170,    1'b0, NO_PAIR},
        // Lowest rate that still enters the search, and the one just below.
        '{27'd4980,      1'b0, NO_PAIR},
        '{27'd4979,      1'b1, '{6'd63, 8'd255, 27'd4979,     1'b0}},
        // Common audio and logic sampling rates.
        '{27'd44100,     1'b0, NO_PAIR},
        '{27'd48000,     1'b0, NO_PAIR},
        '{27'd1000000,   1'b0, NO_PAIR}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    logic [RATE_W-1:0] requested_rate = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    logic [BCK_W-1:0]  bit_clock_divider;
    logic [MCK_W-1:0]  master_clock_divider;
    logic [RATE_W-1:0] achieved_rate;
    logic              error_flag;

    // Expected result beats, oldest first, and the running failure count.
    divider_pair_t expected_pairs [$];
    int unsigned   failures = 0;

    // Set by the stimulus once; the result side then holds off for a long
    // stretch so the output register fills and the request side stalls.
    bit pressure_hold = 1'b0;

    clock_divider_pair_search dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .req_valid            (req_valid),
        .req_ready            (req_ready),
        .requested_rate       (requested_rate),
        .res_valid            (res_valid),
        .res_ready            (res_ready),
        .bit_clock_divider    (bit_clock_divider),
        .master_clock_divider (master_clock_divider),
        .achieved_rate        (achieved_rate),
        .error_flag           (error_flag)
    );

    // 2 ns clock period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Computes the divider pair for one requested rate. The ratio of base
    // clock to rate is split into a bit-clock divider and a master-clock
    // divider; the trial search stops at the first exact fit and otherwise
    // keeps the first divisor with the smallest remainder.
    function automatic divider_pair_t predict_divider_pair(input logic [RATE_W-1:0] rate);
        divider_pair_t pair;
        int unsigned   ratio;
        int unsigned   bck;
        int unsigned   mck;
        int unsigned   quot;
        int unsigned   miss;
        int unsigned   best_miss;
        int unsigned   best_bck;
        int unsigned   prod;
        bit            exact;
        pair = '0;
        if (rate == '0)
        begin
            pair.error_flag = 1'b1;
            return pair;
        end
        ratio = BASE_HZ / {5'd0, rate};
        bck = 1;
        mck = 2;
        if (ratio > TOP_RATIO)
        begin
            bck = TOP_BCK;
            mck = TOP_MCK;
        end
        else if (ratio > 2)
        begin
            best_miss = NO_MISS_YET;
            best_bck = 0;
            exact = 1'b0;
            for (int unsigned d = LOWEST_TRIAL; d <= TOP_BCK && !exact; d++)
            begin
                quot = ratio / d;
                if (quot <= TOP_MCK && quot != 1)
                begin
                    miss = ratio - d * quot;
                    if (miss == 0)
                    begin
                        bck = d;
                        mck = quot;
                        exact = 1'b1;
                    end
                    else if (miss < best_miss)
                    begin
                        best_miss = miss;
                        best_bck = d;
                    end
                end
            end
            if (!exact)
            begin
                if (best_bck == 0)
                    best_bck = TOP_BCK;
                bck = best_bck;
                mck = ratio / bck;
            end
        end
        prod = bck * mck;
        pair.bit_clock_divider = bck[BCK_W-1:0];
        pair.master_clock_divider = mck[MCK_W-1:0];
        if (prod == 0)
            pair.error_flag = 1'b1;
        else
            pair.achieved_rate = RATE_W'(BASE_HZ / prod);
        return pair;
    endfunction

    // Idle lengths: mostly none or short, now and then long enough to cover
    // a whole trial search.
    function automatic int unsigned pick_idle_cycles();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 80)
            return $urandom_range(1, 4);
        if (roll < 95)
            return $urandom_range(5, 40);
        return $urandom_range(100, 1500);
    endfunction

    // Random rates. Most of them land in the search range, either by a
    // chosen ratio (small ratios more often, where the remainder ties and
    // the zero-divider case live) or spread over the whole range. The rest
    // are zero, raw 27-bit values that toggle every bit, rates too low to
    // search and rates too high to search.
    function automatic logic [RATE_W-1:0] pick_rate();
        int unsigned roll;
        int unsigned ratio;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] raw;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return '0;
        if (roll < 14)
        begin
            raw = $urandom();
            return raw[RATE_W-1:0];
        end
        if (roll < 22)
            raw = $urandom_range(1, BASE_HZ / TOP_RATIO);
        else if (roll < 30)
            raw = $urandom_range(BASE_HZ / 3 + 1, BASE_HZ);
        else
        begin
            if (roll < 50)
                ratio = $urandom_range(3, 70);
            else
                ratio = $urandom_range(3, TOP_RATIO);
            // Rates in (BASE_HZ / (ratio + 1), BASE_HZ / ratio] give this
            // ratio; for large ratios the band can be empty.
            lo = BASE_HZ / (ratio + 1) + 1;
            hi = BASE_HZ / ratio;
            raw = (lo <= hi) ? $urandom_range(lo, hi) : hi;
        end
        return raw[RATE_W-1:0];
    endfunction

    // Offers one rate on the request channel after the given idle cycles,
    // holds it until the beat is taken and records its expected result.
    // Entered and left at a falling edge.
    task automatic offer_rate(input logic [RATE_W-1:0] rate, input divider_pair_t want,
                              input int unsigned idle);
        if (idle > 0)
        begin
            req_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        req_valid <= 1'b1;
        requested_rate <= rate;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_pairs.push_back(want);
        @(negedge clk);
    endtask

    // Result side: random stalls and ready stretches, plus the one long
    // hold-off. Ready changes only at falling edges.
    initial
    begin : result_sink
        int unsigned stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (pressure_hold)
            begin
                pressure_hold = 1'b0;
                res_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(negedge clk);
            end
            stall = pick_idle_cycles();
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clk);
        end
    end

    // Every accepted result beat is compared with the oldest expectation.
    // Sampling at the rising edge sees the values from before that edge.
    always @(posedge clk)
    begin
        divider_pair_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_pairs.size() == 0)
            begin
                $error("result beat with no request outstanding");
                failures++;
            end
            else
            begin
                want = expected_pairs.pop_front();
                if (bit_clock_divider !== want.bit_clock_divider)
                begin
                    $error("bit_clock_divider: expected %0d, got %0d",
                           want.bit_clock_divider, bit_clock_divider);
                    failures++;
                end
                if (master_clock_divider !== want.master_clock_divider)
                begin
                    $error("master_clock_divider: expected %0d, got %0d",
                           want.master_clock_divider, master_clock_divider);
                    failures++;
                end
                if (achieved_rate !== want.achieved_rate)
                begin
                    $error("achieved_rate: expected %0d, got %0d",
                           want.achieved_rate, achieved_rate);
                    failures++;
                end
                if (error_flag !== want.error_flag)
                begin
                    $error("error_flag: expected %0d, got %0d",
                           want.error_flag, error_flag);
                    failures++;
                end
            end
        end
    end

    // Request side: reset, the corner table, then the random rates, and
    // finally the drain and the verdict.
    initial
    begin : request_source
        logic [RATE_W-1:0] rate;
        int unsigned       idle;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (CORNER_ROWS[i])
        begin
            offer_rate(CORNER_ROWS[i].rate,
                       CORNER_ROWS[i].typed ? CORNER_ROWS[i].want
                                            : predict_divider_pair(CORNER_ROWS[i].rate),
                       pick_idle_cycles());
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // The request side keeps offering while the result side holds off.
            if (n == PRESSURE_AT)
                pressure_hold = 1'b1;
            // A window of back-to-back requests with no idle cycles at all.
            if (n >= NO_GAP_FIRST && n < NO_GAP_LAST)
                idle = 0;
            else
                idle = pick_idle_cycles();
            rate = pick_rate();
            offer_rate(rate, predict_divider_pair(rate), idle);
        end
        req_valid <= 1'b0;

        // Wait for every outstanding result, then give a stray extra beat
        // time to show up.
        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Safety net against a hung handshake.
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
